/* src/ssba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Item types, operation codes, map geometry and the sector helper.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int SLOTS            = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  localparam int SLOT_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int CNT_W    = 11;
  localparam int OP_W     = 2;

  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = SLOTS / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int LROW_W = CNT_W - BIT_W;

  localparam int FFS_W  = (ROWS > WORD_W) ? ROWS : WORD_W;
  localparam int FFS_IW = $clog2(FFS_W);

  localparam int SPS_W  = $clog2(SECTORS_PER_SLOT + 1);
  localparam int PROD_W = SLOT_W + SPS_W;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_index;
  } ssba_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   result_slot;
    logic [SECTOR_W-1:0] first_sector;
    logic                ok;
  } ssba_out_t;

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [SLOT_W-1:0] slot);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(slot) * PROD_W'(SECTORS_PER_SLOT);
    return prod[SECTOR_W-1:0];
  endfunction

endpackage

/* src/ssba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssba_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ssba_ffs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Find-first-set unit
// Locates the lowest set bit of a vector; shared by row and bit search.
// ----------------------------------------------------------------------------
module ssba_ffs
  import ssba_pkg::*;
(
  input  logic [FFS_W-1:0]  vec_i,
  output logic              found_o,
  output logic [FFS_IW-1:0] idx_o
);

  logic [FFS_W-1:0] lowest;

  assign lowest  = vec_i & (~vec_i + FFS_W'(1));
  assign found_o = |vec_i;

  always_comb begin
    idx_o = '0;
    for (int b = 0; b < FFS_W; b++) begin
      if (lowest[b]) begin
        idx_o = idx_o | FFS_IW'(b);
      end
    end
  end

endmodule

/* src/swap_slot_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit allocator over a free map of swap slots kept in a word-wide RAM.
// ----------------------------------------------------------------------------
// The free map lives in a 32-bit-wide RAM, one row per 32 slots, with a
// flip-flop per row for "row written" and "row has a free slot"; an unwritten
// row reads as all free, so there is no clearing pass after reset. One item
// is in flight at a time. An allocate runs through row pick by the
// find-first-set unit, RAM read, bit pick by the same unit and the result
// register; check and free run through RAM read, word update and result;
// an out-of-range index or an unknown operation goes straight to the result
// register. The result then waits in its register until taken, and the next
// item is accepted in the cycle after that.
module swap_slot_bitmap_allocator
  import ssba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ssba_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ssba_out_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_BIT  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  slot_count_q;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  lim_q;
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] idx_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROWS-1:0]   row_vld_q, nonfull_q;
  ssba_out_t         out_q, out_d;

  logic              in_acc;
  logic [LROW_W-1:0] lim_rows;
  logic [ROWS-1:0]   row_elig;
  logic [WORD_W-1:0] bit_mask;
  logic [ROW_W-1:0]  cur_row;
  logic [WORD_W-1:0] ram_rdata, word, onehot;
  logic              ram_re, ram_we;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [FFS_W-1:0]  ffs_vec;
  logic              ffs_found;
  logic [FFS_IW-1:0] ffs_idx;
  logic              nf_set, nf_clr;
  logic [SLOT_W-1:0] alloc_slot;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;

  assign lim = (slot_count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_q;

  assign lim_rows = lim_q[CNT_W-1:BIT_W] + LROW_W'(|lim_q[BIT_W-1:0]);

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      row_elig[r] = (LROW_W'(r) < lim_rows);
    end
    for (int b = 0; b < WORD_W; b++) begin
      bit_mask[b] = (LROW_W'(row_q) < lim_q[CNT_W-1:BIT_W]) ||
                    ((LROW_W'(row_q) == lim_q[CNT_W-1:BIT_W]) &&
                     (BIT_W'(b) < lim_q[BIT_W-1:0]));
    end
  end

  assign cur_row = (state_q == ST_BIT) ? row_q : idx_q[SLOT_W-1:BIT_W];
  assign word    = row_vld_q[cur_row] ? ram_rdata : '1;

  always_comb begin
    ffs_vec = '0;
    if (state_q == ST_ROW) begin
      ffs_vec[ROWS-1:0] = nonfull_q & row_elig;
    end else begin
      ffs_vec[WORD_W-1:0] = word & bit_mask;
    end
  end

  ssba_ffs u_ffs (
    .vec_i   (ffs_vec),
    .found_o (ffs_found),
    .idx_o   (ffs_idx)
  );

  assign alloc_slot = {row_q, ffs_idx[BIT_W-1:0]};

  always_comb begin
    state_d   = state_q;
    out_d     = out_q;
    row_d     = row_q;
    ram_re    = 1'b0;
    ram_raddr = in_item_i.slot_index[SLOT_W-1:BIT_W];
    ram_we    = 1'b0;
    ram_wdata = word;
    onehot    = '0;
    nf_set    = 1'b0;
    nf_clr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.operation == OP_ALLOC) begin
            state_d = ST_ROW;
          end else if ((in_item_i.operation == OP_CHECK ||
                        in_item_i.operation == OP_FREE) &&
                       (CNT_W'(in_item_i.slot_index) < lim)) begin
            ram_re  = 1'b1;
            state_d = ST_CHK;
          end else begin
            out_d.result_slot  = in_item_i.slot_index;
            out_d.first_sector = '0;
            out_d.ok           = 1'b0;
            state_d            = ST_OUT;
          end
        end
      end
      ST_ROW: begin
        if (ffs_found) begin
          row_d     = ffs_idx[ROW_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = ffs_idx[ROW_W-1:0];
          state_d   = ST_BIT;
        end else begin
          out_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_BIT: begin
        if (ffs_found) begin
          onehot             = WORD_W'(1) << ffs_idx[BIT_W-1:0];
          ram_we             = 1'b1;
          ram_wdata          = word & ~onehot;
          nf_clr             = ~|(word & ~onehot);
          out_d.result_slot  = alloc_slot;
          out_d.first_sector = sector_of(alloc_slot);
          out_d.ok           = 1'b1;
        end else begin
          out_d = '0;
        end
        state_d = ST_OUT;
      end
      ST_CHK: begin
        onehot             = WORD_W'(1) << idx_q[BIT_W-1:0];
        out_d.result_slot  = idx_q;
        out_d.first_sector = sector_of(idx_q);
        if (op_q == OP_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = word | onehot;
          nf_set    = 1'b1;
          out_d.ok  = 1'b1;
        end else begin
          out_d.ok = ~|(word & onehot);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ssba_ram #(
    .Width (WORD_W),
    .Depth (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_row),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_count_q <= CNT_W'(1024);
      row_vld_q    <= '0;
      nonfull_q    <= '1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slot_count_q <= cfg_data_i;
      end
      if (ram_we) begin
        row_vld_q[cur_row] <= 1'b1;
      end
      if (nf_set) begin
        nonfull_q[cur_row] <= 1'b1;
      end else if (nf_clr) begin
        nonfull_q[cur_row] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    row_q <= row_d;
    if (in_acc) begin
      op_q  <= in_item_i.operation;
      idx_q <= in_item_i.slot_index;
      lim_q <= lim;
    end
  end

`ifndef SYNTH
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("block ready while a result is pending");

  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_BIT || state_q == ST_CHK))
    else $error("map written outside an update step");

  a_bit_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIT) |-> ($past(state_q) == ST_ROW))
    else $error("bit search without a row search");

  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.ok && op_q == OP_ALLOC) |->
      (CNT_W'(out_item_o.result_slot) < lim_q))
    else $error("allocated slot beyond slot count");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot allocator testbench
// Drives allocate, check, free and unknown items through the slot allocator
// under random idling, back-pressure and several slot-count settings, and
// compares each result item with a shadow free map or a planned result.
// ----------------------------------------------------------------------------
module testbench;
  import ssba_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int PLAN_ROWS    = 25;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 94;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT        = 400000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             typed;
    ssba_in_t         item;
    logic [CNT_W-1:0] cfg;
    ssba_out_t        want;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  ssba_in_t         in_item_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  ssba_out_t        out_item_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i = '0;

  logic             slot_free [SLOTS];
  logic [CNT_W-1:0] slot_count_shadow;
  ssba_out_t        pending_outcomes [$];
  plan_row_t        plan [PLAN_ROWS];

  int unsigned idle_pct = 14;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;
  int unsigned n_full = 0;
  int unsigned n_range = 0;

  swap_slot_bitmap_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_error(string msg);
    $display("mismatch at cycle %0d: %0s", cycle_count, msg);
    errors++;
  endtask

  function automatic int unsigned usable_slots();
    return (slot_count_shadow > SLOTS) ? SLOTS : int'(slot_count_shadow);
  endfunction

  function automatic logic [SECTOR_W-1:0] slot_sector(int unsigned slot);
    logic [31:0] prod;
    prod = slot * SECTORS_PER_SLOT;
    return prod[SECTOR_W-1:0];
  endfunction

  // Apply one item to the shadow free map and return the result it produces.
  function automatic ssba_out_t slot_outcome(ssba_in_t it);
    ssba_out_t   r;
    int unsigned lim;
    int unsigned idx;
    bit          found;
    lim   = usable_slots();
    idx   = it.slot_index;
    found = 1'b0;
    r.result_slot  = it.slot_index;
    r.first_sector = '0;
    r.ok           = 1'b0;
    case (it.operation)
      OP_ALLOC: begin
        r.result_slot = '0;
        for (int unsigned k = 0; k < lim && !found; k++) begin
          if (slot_free[k]) begin
            slot_free[k]   = 1'b0;
            r.result_slot  = SLOT_W'(k);
            r.first_sector = slot_sector(k);
            r.ok           = 1'b1;
            found          = 1'b1;
          end
        end
        if (!found) n_full++;
      end
      OP_CHECK: begin
        if (idx < lim) begin
          r.first_sector = slot_sector(idx);
          r.ok           = !slot_free[idx];
        end else begin
          n_range++;
        end
      end
      OP_FREE: begin
        if (idx < lim) begin
          slot_free[idx] = 1'b1;
          r.first_sector = slot_sector(idx);
          r.ok           = 1'b1;
        end else begin
          n_range++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.operation  = op;
    row.item.slot_index = idx;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                                          logic [SLOT_W-1:0] slot,
                                          logic [SECTOR_W-1:0] sector, logic ok);
    plan_row_t row;
    row = item_row(op, idx);
    row.typed = 1'b1;
    row.want.result_slot  = slot;
    row.want.first_sector = sector;
    row.want.ok           = ok;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CNT_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg  = value;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(ssba_in_t it, logic typed, ssba_out_t want);
    ssba_out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = slot_outcome(it);
    pending_outcomes.push_back(typed ? want : predicted);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_slot_count(logic [CNT_W-1:0] value);
    drain_outcomes();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_count_shadow = value;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ssba_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_outcomes.size() == 0) begin
        flag_error($sformatf("item with nothing pending: slot %0d",
                             out_item_o.result_slot));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_item_o.result_slot !== want.result_slot)
          flag_error($sformatf("result_slot got %0d want %0d",
                               out_item_o.result_slot, want.result_slot));
        if (out_item_o.first_sector !== want.first_sector)
          flag_error($sformatf("first_sector got %0d want %0d",
                               out_item_o.first_sector, want.first_sector));
        if (out_item_o.ok !== want.ok)
          flag_error($sformatf("ok got %0b want %0b", out_item_o.ok, want.ok));
      end
    end
  end

  initial begin
    ssba_in_t    it;
    int unsigned lim;
    int unsigned alloc_pct;
    int unsigned r;

    for (int k = 0; k < SLOTS; k++) slot_free[k] = 1'b1;
    slot_count_shadow = CNT_W'(SLOTS);

    plan[0]  = known_row(OP_ALLOC, 10'd0,    10'd0,    13'd0,    1'b1);
    plan[1]  = known_row(OP_ALLOC, 10'd1023, 10'd1,    13'd8,    1'b1);
    plan[2]  = known_row(OP_CHECK, 10'd0,    10'd0,    13'd0,    1'b1);
    plan[3]  = known_row(OP_CHECK, 10'd1023, 10'd1023, 13'd8184, 1'b0);
    plan[4]  = known_row(OP_FREE,  10'd1023, 10'd1023, 13'd8184, 1'b1);
    plan[5]  = known_row(OP_FREE,  10'd0,    10'd0,    13'd0,    1'b1);
    plan[6]  = known_row(OP_ALLOC, 10'd0,    10'd0,    13'd0,    1'b1);
    plan[7]  = known_row(OP_NONE,  10'd1023, 10'd1023, 13'd0,    1'b0);
    plan[8]  = known_row(OP_NONE,  10'd0,    10'd0,    13'd0,    1'b0);
    plan[9]  = cfg_row(11'd0);
    plan[10] = known_row(OP_ALLOC, 10'd0,    10'd0,    13'd0,    1'b0);
    plan[11] = known_row(OP_CHECK, 10'd0,    10'd0,    13'd0,    1'b0);
    plan[12] = known_row(OP_FREE,  10'd1,    10'd1,    13'd0,    1'b0);
    plan[13] = cfg_row(11'd2047);
    plan[14] = known_row(OP_CHECK, 10'd1023, 10'd1023, 13'd8184, 1'b0);
    plan[15] = known_row(OP_CHECK, 10'd1,    10'd1,    13'd8,    1'b1);
    plan[16] = cfg_row(11'd2);
    plan[17] = known_row(OP_ALLOC, 10'd0,    10'd0,    13'd0,    1'b0);
    plan[18] = known_row(OP_CHECK, 10'd2,    10'd2,    13'd0,    1'b0);
    plan[19] = known_row(OP_FREE,  10'd1,    10'd1,    13'd8,    1'b1);
    plan[20] = known_row(OP_ALLOC, 10'd682,  10'd1,    13'd8,    1'b1);
    plan[21] = cfg_row(11'd1024);
    plan[22] = item_row(OP_ALLOC, 10'd341);
    plan[23] = item_row(OP_FREE,  10'd341);
    plan[24] = item_row(OP_CHECK, 10'd2);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_slot_count(plan[i].cfg);
      else push_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_slot_count(11'd1);
        1:       write_slot_count(11'd2047);
        2:       write_slot_count(11'd1024);
        3:       write_slot_count(CNT_W'($urandom_range(0, 2047)));
        default: write_slot_count(CNT_W'($urandom_range(2, 64)));
      endcase
      idle_pct  = (p == 4) ? 0 : 14;
      alloc_pct = (p % 2 == 1) ? 60 : 35;
      lim       = usable_slots();
      // hold the receiver while items keep coming
      if (p == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender until every pending result is back
        if (p == 5 && n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          while (pending_outcomes.size() != 0) @(negedge clk_i);
        end
        r = $urandom_range(0, 99);
        if (r < 3) it.operation = OP_NONE;
        else if (r < alloc_pct) it.operation = OP_ALLOC;
        else if (r < alloc_pct + (100 - alloc_pct) / 2) it.operation = OP_CHECK;
        else it.operation = OP_FREE;
        if (lim != 0 && $urandom_range(0, 3) != 0)
          it.slot_index = SLOT_W'($urandom_range(0, lim - 1));
        else
          it.slot_index = SLOT_W'($urandom_range(0, SLOTS - 1));
        push_item(it, 1'b0, '0);
      end
    end

    drain_outcomes();
    if (pending_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
    $display("summary: %0d items, %0d results, %0d slot-count writes",
             n_items, n_results, n_cfg);
    $display("summary: %0d allocates on a full map, %0d out-of-range checks or frees",
             n_full, n_range);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
